/* hw/rtl/md5_pkg.sv */
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables for the MD5 digest block.
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam int BlockBytes = 64;
  localparam int BlockWords = 16;
  localparam int Rounds     = 64;
  localparam int LengthPos  = 56;

  localparam logic [7:0]  PadByte  = 8'h80;
  localparam logic [31:0] InitA    = 32'h67452301;
  localparam logic [31:0] InitB    = 32'hEFCDAB89;
  localparam logic [31:0] InitC    = 32'h98BADCFE;
  localparam logic [31:0] InitD    = 32'h10325476;

  localparam logic KindByte   = 1'b0;
  localparam logic KindFinish = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_RUN,
    ST_FOLD,
    ST_OUT
  } state_t;

  // Round-unit control from the sequencer.
  typedef struct packed {
    logic       start;
    logic       step;
    logic       fold;
    logic       init;
    logic [5:0] round;
  } round_ctl_t;

  function automatic logic [31:0] round_const(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0:  k = 32'hD76AA478; 6'd1:  k = 32'hE8C7B756;
      6'd2:  k = 32'h242070DB; 6'd3:  k = 32'hC1BDCEEE;
      6'd4:  k = 32'hF57C0FAF; 6'd5:  k = 32'h4787C62A;
      6'd6:  k = 32'hA8304613; 6'd7:  k = 32'hFD469501;
      6'd8:  k = 32'h698098D8; 6'd9:  k = 32'h8B44F7AF;
      6'd10: k = 32'hFFFF5BB1; 6'd11: k = 32'h895CD7BE;
      6'd12: k = 32'h6B901122; 6'd13: k = 32'hFD987193;
      6'd14: k = 32'hA679438E; 6'd15: k = 32'h49B40821;
      6'd16: k = 32'hF61E2562; 6'd17: k = 32'hC040B340;
      6'd18: k = 32'h265E5A51; 6'd19: k = 32'hE9B6C7AA;
      6'd20: k = 32'hD62F105D; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hD8A1E681; 6'd23: k = 32'hE7D3FBC8;
      6'd24: k = 32'h21E1CDE6; 6'd25: k = 32'hC33707D6;
      6'd26: k = 32'hF4D50D87; 6'd27: k = 32'h455A14ED;
      6'd28: k = 32'hA9E3E905; 6'd29: k = 32'hFCEFA3F8;
      6'd30: k = 32'h676F02D9; 6'd31: k = 32'h8D2A4C8A;
      6'd32: k = 32'hFFFA3942; 6'd33: k = 32'h8771F681;
      6'd34: k = 32'h6D9D6122; 6'd35: k = 32'hFDE5380C;
      6'd36: k = 32'hA4BEEA44; 6'd37: k = 32'h4BDECFA9;
      6'd38: k = 32'hF6BB4B60; 6'd39: k = 32'hBEBFBC70;
      6'd40: k = 32'h289B7EC6; 6'd41: k = 32'hEAA127FA;
      6'd42: k = 32'hD4EF3085; 6'd43: k = 32'h04881D05;
      6'd44: k = 32'hD9D4D039; 6'd45: k = 32'hE6DB99E5;
      6'd46: k = 32'h1FA27CF8; 6'd47: k = 32'hC4AC5665;
      6'd48: k = 32'hF4292244; 6'd49: k = 32'h432AFF97;
      6'd50: k = 32'hAB9423A7; 6'd51: k = 32'hFC93A039;
      6'd52: k = 32'h655B59C3; 6'd53: k = 32'h8F0CCC92;
      6'd54: k = 32'hFFEFF47D; 6'd55: k = 32'h85845DD1;
      6'd56: k = 32'h6FA87E4F; 6'd57: k = 32'hFE2CE6E0;
      6'd58: k = 32'hA3014314; 6'd59: k = 32'h4E0811A1;
      6'd60: k = 32'hF7537E82; 6'd61: k = 32'hBD3AF235;
      6'd62: k = 32'h2AD7D2BB; 6'd63: k = 32'hEB86D391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Message word index used by round i.
  function automatic logic [3:0] word_index(input logic [5:0] i);
    logic [3:0] g;
    unique case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(5 * i + 1);
      2'd2: g = 4'(3 * i + 5);
      2'd3: g = 4'(7 * i);
      default: g = 4'd0;
    endcase
    return g;
  endfunction

endpackage

/* hw/rtl/md5_if.sv */
// ----------------------------------------------------------------------------
// md5_in_if / md5_out_if
// Valid/ready channels for message bytes and digests.
// ----------------------------------------------------------------------------
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  modport source (output valid, kind, data_byte, input ready);
  modport sink (input valid, kind, data_byte, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_low;
  logic [63:0] digest_high;
  modport source (output valid, digest_low, digest_high, input ready);
  modport sink (input valid, digest_low, digest_high, output ready);
endinterface

/* hw/rtl/md5_round.sv */
// ----------------------------------------------------------------------------
// md5_compress_core
// Shared MD5 round unit: one round per step, chaining-word fold at the end.
// ----------------------------------------------------------------------------
module md5_compress_core import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  round_ctl_t  ctl,
  input  logic [31:0] word,
  output logic [31:0] chain_a,
  output logic [31:0] chain_b,
  output logic [31:0] chain_c,
  output logic [31:0] chain_d
);

  logic [31:0] a, b, c, d;
  logic [31:0] f, sum, rot;
  logic [4:0]  s;

  always_comb begin
    unique case (ctl.round[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      2'd3: f = c ^ (b | ~d);
      default: f = '0;
    endcase
    sum = a + f + word + round_const(ctl.round);
    s   = rot_amount(ctl.round);
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a <= chain_a; b <= chain_b; c <= chain_c; d <= chain_d;
    end else if (ctl.step) begin
      a <= d; d <= c; c <= b; b <= b + rot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.init) begin
      chain_a <= InitA; chain_b <= InitB; chain_c <= InitC; chain_d <= InitD;
    end else if (ctl.fold) begin
      chain_a <= chain_a + a; chain_b <= chain_b + b;
      chain_c <= chain_c + c; chain_d <= chain_d + d;
    end
  end

endmodule

/* hw/rtl/md5_buffer.sv */
// ----------------------------------------------------------------------------
// md5_buffer
// 64-byte block buffer; byte writes in, round words read out by index.
// ----------------------------------------------------------------------------
module md5_buffer import md5_pkg::*; (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [5:0]  wr_addr,
  input  logic [7:0]  wr_data,
  input  logic [3:0]  rd_word,
  output logic [31:0] rd_data
);

  // Sixteen little-endian words; a byte write updates one lane of one word.
  logic [31:0] words [BlockWords];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      words[wr_addr[5:2]][{wr_addr[1:0], 3'b000} +: 8] <= wr_data;
    end
  end

  // One word read per round: a 16-way mux.
  assign rd_data = words[rd_word];

endmodule

/* hw/rtl/md5_message_digest.sv */
// ----------------------------------------------------------------------------
// md5_message_digest
// MD5 hash over a byte stream, one shared round unit.
// ----------------------------------------------------------------------------
// A message byte is taken while the input is ready; the byte that completes a
// 64-byte block starts a compression (64 rounds on the single round unit and
// one fold; the load of the round unit overlaps the byte transfer), during
// which the input is not ready. A finish item writes the pad byte with its
// transfer, then fills the rest of the block one byte a cycle, runs one or two
// compressions, and offers the digest in an output register; the input is not
// ready until the digest has been taken.
module md5_message_digest import md5_pkg::*; (
  input logic  clk,
  input logic  rst,
  md5_in_if.sink    in_ch,
  md5_out_if.source out_ch
);

  state_t      state, state_next;
  logic [63:0] byte_count, bit_len;
  logic [5:0]  ptr;
  logic [5:0]  round;
  logic        finishing, last_block;
  round_ctl_t  ctl;
  logic        wr_en;
  logic [5:0]  wr_addr;
  logic [7:0]  wr_data;
  logic [31:0] word, chain_a, chain_b, chain_c, chain_d;
  logic        accept;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ST_IDLE);
  assign bit_len = {byte_count[60:0], 3'b000};

  md5_buffer u_buf (
    .clk, .wr_en, .wr_addr, .wr_data, .rd_word(word_index(round)), .rd_data(word)
  );

  md5_compress_core u_round (
    .clk, .rst, .ctl, .word, .chain_a, .chain_b, .chain_c, .chain_d
  );

  always_comb begin
    state_next = state;
    wr_en   = 1'b0;
    wr_addr = ptr;
    wr_data = in_ch.data_byte;
    ctl     = '0;
    ctl.round = round;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          wr_en   = 1'b1;
          wr_addr = byte_count[5:0];
          if (in_ch.kind == KindByte) begin
            if (byte_count[5:0] == 6'h3F) begin
              state_next = ST_RUN;
              ctl.start  = 1'b1;
            end
          end else begin
            wr_data = PadByte;
            if (byte_count[5:0] == 6'h3F) begin
              // Pad byte fills the block: compress it straight away.
              state_next = ST_RUN;
              ctl.start  = 1'b1;
            end else begin
              state_next = ST_PAD;
            end
          end
        end
      end
      ST_PAD: begin
        // Fill zeros, then the length word once it fits in this block.
        wr_en = 1'b1;
        if (last_block && ptr >= 6'(LengthPos)) begin
          wr_data = bit_len[{ptr[2:0], 3'b000} +: 8];
        end else begin
          wr_data = 8'h00;
        end
        if (ptr == 6'h3F) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        ctl.step = 1'b1;
        if (round == 6'(Rounds - 1)) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        ctl.fold = 1'b1;
        if (!finishing) begin
          state_next = ST_IDLE;
        end else if (last_block) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          ctl.init   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    // Load the round unit from the chaining words in the cycle before the rounds.
    if (state == ST_PAD && ptr == 6'h3F) begin
      ctl.start = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      ptr        <= '0;
      round      <= '0;
      finishing  <= 1'b0;
      last_block <= 1'b0;
    end else begin
      if (accept) begin
        if (in_ch.kind == KindByte) begin
          byte_count <= byte_count + 64'd1;
          finishing  <= 1'b0;
        end else begin
          finishing  <= 1'b1;
          last_block <= (byte_count[5:0] < 6'(LengthPos));
          ptr        <= byte_count[5:0] + 6'd1;
        end
      end
      if (state == ST_PAD) begin
        ptr <= ptr + 6'd1;
      end
      if (state == ST_RUN) begin
        round <= round + 6'd1;
      end
      if (state == ST_FOLD && finishing && !last_block) begin
        last_block <= 1'b1;
        ptr        <= '0;
      end
      if (state == ST_OUT && out_ch.ready) begin
        byte_count <= '0;
        finishing  <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = (state == ST_OUT);
  assign out_ch.digest_low  = {chain_b, chain_a};
  assign out_ch.digest_high = {chain_d, chain_c};

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("input ready while digest pending");
  a_round_wrap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FOLD) |-> (round == 6'd0)) else $error("round count off at fold");
  a_run_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && round == 6'd63) |=> (state == ST_FOLD))
    else $error("rounds did not end in fold");
  a_out_clear: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready) |=> (byte_count == 64'd0))
    else $error("count not cleared after digest");
`endif

endmodule
